[design/rgs_pkg.sv]
// Shared constants, request codes and walker types for the resizable grid store.
// No dependencies; imported by every module of the block except rgs_ram.
package rgs_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 8;
    localparam int IDX_W    = 7;

    localparam logic [1:0] REQ_GET    = 2'd0;
    localparam logic [1:0] REQ_SET    = 2'd1;
    localparam logic [1:0] REQ_RESIZE = 2'd2;
    localparam logic [1:0] REQ_CREATE = 2'd3;

    // Shape information held steady for a whole resize walk
    typedef struct packed {
        logic [CNT_W-1:0] old_cols;
        logic [CNT_W-1:0] new_cols;
        logic [CNT_W-1:0] keep_rows;
        logic [CNT_W-1:0] keep_cols;
    } walk_cfg_t;

    // One step of the resize walk
    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic              keep;
        logic              last;
    } walk_t;

endpackage

[design/rgs_ram.sv]
// Generic simple dual-port synchronous RAM, one write and one registered read port.
// No package dependency.
module rgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/rgs_walk.sv]
// Address walker for the second resize pass: steps every destination word in order.
// Depends on rgs_pkg for widths and the walk structs.
module rgs_walk
    import rgs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      init,
    input  logic      step,
    input  walk_cfg_t cfg,
    output walk_t     walk
);

    logic [ADDR_W-1:0] dst_reg;
    logic [CNT_W-1:0]  row_reg;
    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  base_reg;
    logic [CNT_W-1:0]  src_full;
    logic              wrap;

    assign src_full = base_reg + col_reg;
    assign wrap     = (col_reg + 8'd1) == cfg.new_cols;

    assign walk.src  = src_full[ADDR_W-1:0];
    assign walk.dst  = dst_reg;
    assign walk.keep = (row_reg < cfg.keep_rows) && (col_reg < cfg.keep_cols);
    assign walk.last = dst_reg == ADDR_W'(CAPACITY - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            base_reg <= '0;
        end
        else if (init)
        begin
            dst_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            base_reg <= '0;
        end
        else if (step)
        begin
            dst_reg <= dst_reg + 1'b1;
            if (wrap)
            begin
                col_reg <= '0;
                row_reg <= row_reg + 8'd1;
                // advance the source row only while it still holds kept cells
                if (row_reg < cfg.keep_rows)
                begin
                    base_reg <= base_reg + cfg.old_cols;
                end
            end
            else
            begin
                col_reg <= col_reg + 8'd1;
            end
        end
    end

endmodule

[design/resizable_grid_store.sv]
// Top level of the resizable grid store: request decode, sequencer and result register.
// Depends on rgs_pkg, rgs_ram (grid and scratch stores) and rgs_walk.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  request | in        | in_valid/in_stall  | req_type row col write_value new_rows/cols
//  result  | out       | out_valid/out_stall| ok read_value cur_rows cur_cols
//
// One item is worked on at a time; an item is taken only when the sequencer is idle,
// but the previous result may still sit in the output register.
// Set, create and any refused item go straight to the done state; a get first does one RAM read.
// Resize: one grid-store pass to copy into scratch and one pass writing every grid word
// back, each one word a cycle through the single RAM ports.
// Reset needs no clearing pass: a valid bit per grid word makes unwritten words read as
// zero, and create clears all valid bits at once. A stalled result only holds the item
// after it in the done state; nothing else waits on out_stall.
module resizable_grid_store
    import rgs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              req_type,
    input  logic [IDX_W-1:0]        row,
    input  logic [IDX_W-1:0]        col,
    input  logic signed [DATA_W-1:0] write_value,
    input  logic [CNT_W-1:0]        new_rows,
    input  logic [CNT_W-1:0]        new_cols,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    ok,
    output logic signed [DATA_W-1:0] read_value,
    output logic [CNT_W-1:0]        cur_rows,
    output logic [CNT_W-1:0]        cur_cols
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GET  = 3'd1;
    localparam logic [2:0] ST_COPY = 3'd2;
    localparam logic [2:0] ST_MOVE = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;

    logic [CNT_W-1:0]  row_count_reg;
    logic [CNT_W-1:0]  col_count_reg;
    logic [CAPACITY-1:0] vld_reg;

    // pending resize shape
    logic [CNT_W-1:0]  rs_rows_reg;
    logic [CNT_W-1:0]  rs_cols_reg;
    logic [CNT_W-1:0]  keep_rows_reg;
    logic [CNT_W-1:0]  keep_cols_reg;

    // result waiting for the output register
    logic              res_ok_reg;
    logic [DATA_W-1:0] res_val_reg;

    // output register
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [DATA_W-1:0] out_val_reg;
    logic [CNT_W-1:0]  out_rows_reg;
    logic [CNT_W-1:0]  out_cols_reg;

    // copy pass
    logic [ADDR_W-1:0] cp_idx_reg;
    logic              cp_wr_reg;
    logic [ADDR_W-1:0] cp_addr_reg;
    logic              cp_vld_reg;

    // move pass
    logic              mv_wr_reg;
    logic [ADDR_W-1:0] mv_dst_reg;
    logic              mv_keep_reg;

    logic              rd_vld_reg;

    logic              in_take;
    logic              out_free;
    logic              in_grid;
    logic              fits;
    logic [14:0]       idx_full;
    logic [ADDR_W-1:0] idx;
    logic [15:0]       shape_cells;
    logic [CNT_W-1:0]  keep_rows;
    logic [CNT_W-1:0]  keep_cols;

    logic              grid_we;
    logic [ADDR_W-1:0] grid_waddr;
    logic [DATA_W-1:0] grid_wdata;
    logic [ADDR_W-1:0] grid_raddr;
    logic [DATA_W-1:0] grid_rdata;
    logic [DATA_W-1:0] scr_wdata;
    logic [DATA_W-1:0] scr_rdata;

    logic              set_write;
    logic              walk_init;
    logic              walk_step;
    walk_cfg_t         walk_cfg;
    walk_t             walk;

    // ---------------------------------------------------------------- decode
    assign in_stall = state_reg != ST_IDLE;
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign idx_full    = 15'(row) * 15'(col_count_reg) + 15'(col);
    assign idx         = idx_full[ADDR_W-1:0];
    assign in_grid     = ({1'b0, row} < row_count_reg) && ({1'b0, col} < col_count_reg);
    assign shape_cells = 16'(new_rows) * 16'(new_cols);
    assign fits        = shape_cells <= 16'(CAPACITY);
    assign keep_rows   = (new_rows < row_count_reg) ? new_rows : row_count_reg;
    assign keep_cols   = (new_cols < col_count_reg) ? new_cols : col_count_reg;

    assign set_write = in_take && (req_type == REQ_SET) && in_grid;
    assign walk_init = in_take && (req_type == REQ_RESIZE) && fits;
    assign walk_step = state_reg == ST_MOVE;

    // ---------------------------------------------------------------- stores
    // Grid writes come from a set or from the move pass; they never overlap.
    assign grid_we    = set_write || mv_wr_reg;
    assign grid_waddr = mv_wr_reg ? mv_dst_reg : idx;
    assign grid_wdata = mv_wr_reg ? (mv_keep_reg ? scr_rdata : '0) : write_value;
    assign grid_raddr = (state_reg == ST_COPY) ? cp_idx_reg : idx;

    // a word never written since create or reset copies over as zero
    assign scr_wdata = cp_vld_reg ? grid_rdata : '0;

    rgs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    // The last copy write (top word) lands in the first move cycle, whose read is
    // always word zero, so the two passes need no gap between them.
    rgs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_scratch (
        .clk   (clk),
        .we    (cp_wr_reg),
        .waddr (cp_addr_reg),
        .wdata (scr_wdata),
        .raddr (walk.src),
        .rdata (scr_rdata)
    );

    assign walk_cfg.old_cols  = col_count_reg;
    assign walk_cfg.new_cols  = rs_cols_reg;
    assign walk_cfg.keep_rows = keep_rows_reg;
    assign walk_cfg.keep_cols = keep_cols_reg;

    rgs_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .init  (walk_init),
        .step  (walk_step),
        .cfg   (walk_cfg),
        .walk  (walk)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (req_type == REQ_GET && in_grid)
                    begin
                        state_next = ST_GET;
                    end
                    else if (req_type == REQ_RESIZE && fits)
                    begin
                        state_next = ST_COPY;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_GET:
            begin
                state_next = ST_DONE;
            end
            ST_COPY:
            begin
                if (cp_idx_reg == ADDR_W'(CAPACITY - 1))
                begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                if (walk.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_count_reg <= '0;
            col_count_reg <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            cp_idx_reg    <= '0;
            cp_wr_reg     <= 1'b0;
            mv_wr_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cp_wr_reg <= state_reg == ST_COPY;
            mv_wr_reg <= state_reg == ST_MOVE;

            if (in_take && req_type == REQ_CREATE && fits)
            begin
                row_count_reg <= new_rows;
                col_count_reg <= new_cols;
                vld_reg       <= '0;
            end
            else if (set_write)
            begin
                vld_reg[idx] <= 1'b1;
            end
            else if (mv_wr_reg)
            begin
                // zero-filled words are written too, so mark them valid
                vld_reg[mv_dst_reg] <= 1'b1;
            end

            // adopt the new shape once the last destination word is issued
            if (state_reg == ST_MOVE && walk.last)
            begin
                row_count_reg <= rs_rows_reg;
                col_count_reg <= rs_cols_reg;
            end

            if (walk_init)
            begin
                cp_idx_reg <= '0;
            end
            else if (state_reg == ST_COPY)
            begin
                cp_idx_reg <= cp_idx_reg + 1'b1;
            end

            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_vld_reg  <= vld_reg[grid_raddr];
        cp_vld_reg  <= vld_reg[grid_raddr];
        cp_addr_reg <= cp_idx_reg;
        mv_dst_reg  <= walk.dst;
        mv_keep_reg <= walk.keep;

        if (in_take)
        begin
            rs_rows_reg   <= new_rows;
            rs_cols_reg   <= new_cols;
            keep_rows_reg <= keep_rows;
            keep_cols_reg <= keep_cols;
            res_val_reg   <= '0;
            case (req_type)
                REQ_GET:    res_ok_reg <= in_grid;
                REQ_SET:    res_ok_reg <= in_grid;
                REQ_RESIZE: res_ok_reg <= fits;
                REQ_CREATE: res_ok_reg <= fits;
                default:    res_ok_reg <= 1'b0;
            endcase
        end

        if (state_reg == ST_GET)
        begin
            res_val_reg <= rd_vld_reg ? grid_rdata : '0;
        end

        if (state_reg == ST_DONE && out_free)
        begin
            out_ok_reg   <= res_ok_reg;
            out_val_reg  <= res_val_reg;
            out_rows_reg <= row_count_reg;
            out_cols_reg <= col_count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = out_ok_reg;
    assign read_value = out_val_reg;
    assign cur_rows   = out_rows_reg;
    assign cur_cols   = out_cols_reg;

    // ---------------------------------------------------------------- checks
    // the stored shape never exceeds the store
    assert property (@(posedge clk) disable iff (!rst_n)
        (16'(row_count_reg) * 16'(col_count_reg)) <= 16'(CAPACITY))
    else $error("grid shape exceeds capacity");

    // the move pass never writes while the copy pass is still reading the grid
    assert property (@(posedge clk) disable iff (!rst_n)
        mv_wr_reg |-> (state_reg != ST_COPY))
    else $error("move write during copy pass");

    // the end of the move pass adopts the pending shape and hands over the result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE && walk.last) |=>
            (state_reg == ST_DONE && row_count_reg == $past(rs_rows_reg)
             && col_count_reg == $past(rs_cols_reg)))
    else $error("resize did not complete cleanly");

endmodule

[test/grid_store_checker.sv]
// Checker for the resizable grid store: watches both channels, predicts each result
// and compares it field by field. Depends on rgs_pkg.
module grid_store_checker
    import rgs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [1:0]               req_type,
    input  logic [IDX_W-1:0]         row,
    input  logic [IDX_W-1:0]         col,
    input  logic signed [DATA_W-1:0] write_value,
    input  logic [CNT_W-1:0]         new_rows,
    input  logic [CNT_W-1:0]         new_cols,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic                     ok,
    input  logic signed [DATA_W-1:0] read_value,
    input  logic [CNT_W-1:0]         cur_rows,
    input  logic [CNT_W-1:0]         cur_cols,
    output int                       fail_count,
    output int                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  rows;
        logic [CNT_W-1:0]  cols;
    } grid_reply_t;

    logic [DATA_W-1:0] cells [CAPACITY];
    logic [CNT_W-1:0]  shadow_rows;
    logic [CNT_W-1:0]  shadow_cols;
    grid_reply_t       replies_due [$];

    // Apply one request to the shadow grid and return the reply it should produce
    function automatic grid_reply_t apply_request(input logic [1:0] kind,
                                                  input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c,
                                                  input logic [DATA_W-1:0] wv,
                                                  input logic [CNT_W-1:0] nr,
                                                  input logic [CNT_W-1:0] nc);
        grid_reply_t       reply;
        logic [DATA_W-1:0] fresh [CAPACITY];
        int                idx;
        int                keep_r;
        int                keep_c;
        reply = '0;
        if (kind == REQ_GET || kind == REQ_SET)
        begin
            if (r < shadow_rows && c < shadow_cols)
            begin
                idx = int'(r) * int'(shadow_cols) + int'(c);
                reply.ok = 1'b1;
                if (kind == REQ_GET)
                    reply.value = cells[idx];
                else
                    cells[idx] = wv;
            end
        end
        else if (int'(nr) * int'(nc) <= CAPACITY)
        begin
            for (int i = 0; i < CAPACITY; i++)
                fresh[i] = '0;
            if (kind == REQ_RESIZE)
            begin
                keep_r = (nr < shadow_rows) ? int'(nr) : int'(shadow_rows);
                keep_c = (nc < shadow_cols) ? int'(nc) : int'(shadow_cols);
                for (int i = 0; i < keep_r; i++)
                    for (int j = 0; j < keep_c; j++)
                        fresh[i * int'(nc) + j] = cells[i * int'(shadow_cols) + j];
            end
            cells       = fresh;
            shadow_rows = nr;
            shadow_cols = nc;
            reply.ok    = 1'b1;
        end
        reply.rows = shadow_rows;
        reply.cols = shadow_cols;
        return reply;
    endfunction

    task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grid_reply_t oldest;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                cells[i] = '0;
            shadow_rows = '0;
            shadow_cols = '0;
            replies_due.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t ns: no result expected, got ok %b value %h dims %0d x %0d",
                             $time, ok, read_value, cur_rows, cur_cols);
                    fail_count++;
                end
                else
                begin
                    oldest = replies_due.pop_front();
                    check_field("ok", DATA_W'(oldest.ok), DATA_W'(ok));
                    check_field("read_value", oldest.value, read_value);
                    check_field("cur_rows", DATA_W'(oldest.rows), DATA_W'(cur_rows));
                    check_field("cur_cols", DATA_W'(oldest.cols), DATA_W'(cur_cols));
                end
            end
            if (in_valid && !in_stall)
                replies_due.push_back(apply_request(req_type, row, col, write_value,
                                                    new_rows, new_cols));
            outstanding <= replies_due.size();
        end
    end

endmodule

[test/tb_resizable_grid_store.sv]
// Testbench top for the resizable grid store: clock, reset, request stimulus, result stall
// and the verdict. Depends on rgs_pkg, resizable_grid_store and grid_store_checker.
module tb_resizable_grid_store;
    timeunit 1ns;
    timeprecision 1ps;
    import rgs_pkg::*;

    // Generous ceiling: a resize walk passes twice over the whole store, and even a run
    // made only of resizes under heavy stall stays well inside this.
    localparam int RUN_LIMIT    = 5_000_000;
    // Idle time after the last result, enough for a full resize walk to show itself
    localparam int TAIL_CYCLES  = 2 * CAPACITY + 16;
    localparam int RANDOM_ITEMS = 1400;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic [1:0]               req_type    = REQ_GET;
    logic [IDX_W-1:0]         row         = '0;
    logic [IDX_W-1:0]         col         = '0;
    logic signed [DATA_W-1:0] write_value = '0;
    logic [CNT_W-1:0]         new_rows    = '0;
    logic [CNT_W-1:0]         new_cols    = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         cur_rows;
    logic [CNT_W-1:0]         cur_cols;
    int                       fail_count;
    int                       outstanding;

    int cycle_count = 0;
    int burst_left  = 0;
    int stall_span  = 0;
    int stall_pct   = 0;
    // Shape the grid should have, tracked only to aim gets and sets inside it
    int shape_rows  = 0;
    int shape_cols  = 0;

    resizable_grid_store uut (.*);

    grid_store_checker checker_i (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends up here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result stall: hold a stall rate for a random stretch, then pick another.
    // Zero is picked often so that long stall-free runs occur too.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_span <= 0;
            stall_pct  <= 0;
        end
        else
        begin
            if (stall_span == 0)
            begin
                stall_span <= $urandom_range(5, 80);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct <= 0;
                    2:       stall_pct <= 25;
                    3:       stall_pct <= 60;
                    default: stall_pct <= 90;
                endcase
            end
            else
            begin
                stall_span <= stall_span - 1;
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Drop valid and hold off after a burst; otherwise keep valid high for the next item.
    // The gap always waits on the clock, so valid is never lowered and raised in one step.
    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Present one request, hold it until taken, then advance the burst pacing
    task automatic send_request(input logic [1:0] kind, input int r, input int c,
                                input logic [DATA_W-1:0] wv, input int nr, input int nc);
        in_valid    <= 1'b1;
        req_type    <= kind;
        row         <= r[IDX_W-1:0];
        col         <= c[IDX_W-1:0];
        write_value <= wv;
        new_rows    <= nr[CNT_W-1:0];
        new_cols    <= nc[CNT_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if ((kind == REQ_RESIZE || kind == REQ_CREATE) && nr * nc <= CAPACITY)
        begin
            shape_rows = nr;
            shape_cols = nc;
        end
        pace();
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed traffic: gets and sets aimed inside the current grid, with
    // shapes that fit, plus a share of off-grid positions and oversized shapes.
    task automatic random_request();
        int         pick;
        int         r;
        int         c;
        int         nr;
        int         nc;
        logic [1:0] kind;
        pick = $urandom_range(0, 99);
        r    = $urandom_range(0, 127);
        c    = $urandom_range(0, 127);
        if (shape_rows > 0 && shape_cols > 0 && $urandom_range(0, 9) < 8)
        begin
            r = $urandom_range(0, shape_rows - 1);
            c = $urandom_range(0, shape_cols - 1);
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            // just off the edge of the grid
            r = (shape_rows < 128) ? shape_rows : 127;
            c = $urandom_range(0, (shape_cols > 0) ? shape_cols - 1 : 0);
        end
        case ($urandom_range(0, 19))
            0, 1:
            begin
                nr = $urandom_range(0, 255);
                nc = $urandom_range(0, 255);
            end
            2:
            begin
                nr = ($urandom_range(0, 1) == 0) ? 128 : 1;
                nc = (nr == 128) ? $urandom_range(0, 1) : 128;
            end
            default:
            begin
                nr = $urandom_range(0, 12);
                nc = (nr == 0) ? $urandom_range(0, 255) : $urandom_range(0, CAPACITY / nr);
            end
        endcase
        if (pick < 40)
            kind = REQ_GET;
        else if (pick < 78)
            kind = REQ_SET;
        else if (pick < 92)
            kind = REQ_RESIZE;
        else
            kind = REQ_CREATE;
        send_request(kind, r, c, $urandom, nr, nc);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty grid after reset: every access is refused
        send_request(REQ_GET, 0, 0, 32'h0, 0, 0);
        send_request(REQ_SET, 0, 0, 32'h5A5A_5A5A, 0, 0);
        // Oversized shapes are refused, the boundary shapes are taken
        send_request(REQ_CREATE, 0, 0, 32'h0, 255, 255);
        send_request(REQ_CREATE, 0, 0, 32'h0, 129, 1);
        send_request(REQ_CREATE, 0, 0, 32'h0, 128, 1);
        send_request(REQ_SET, 127, 0, 32'h7FFF_FFFF, 0, 0);
        send_request(REQ_GET, 127, 0, 32'h0, 0, 0);
        send_request(REQ_SET, 0, 0, 32'hFFFF_FFFF, 0, 0);
        // Tall to wide: only cell (0,0) survives
        send_request(REQ_RESIZE, 0, 0, 32'h0, 1, 128);
        send_request(REQ_GET, 0, 0, 32'h0, 0, 0);
        send_request(REQ_SET, 0, 127, 32'h8000_0000, 0, 0);
        send_request(REQ_GET, 0, 127, 32'h0, 0, 0);
        send_request(REQ_GET, 1, 0, 32'h0, 0, 0);
        // Empty shape is accepted, then nothing inside it is
        send_request(REQ_CREATE, 0, 0, 32'h0, 0, 5);
        send_request(REQ_GET, 0, 0, 32'h0, 0, 0);
        send_request(REQ_RESIZE, 0, 0, 32'h0, 11, 11);
        send_request(REQ_SET, 10, 10, 32'hFFFF_FFFF, 0, 0);
        send_request(REQ_SET, 0, 0, 32'd12345, 0, 0);
        // Fewer rows, more columns: overlapping cells keep their place
        send_request(REQ_RESIZE, 0, 0, 32'h0, 8, 16);
        send_request(REQ_GET, 0, 0, 32'h0, 0, 0);
        send_request(REQ_RESIZE, 0, 0, 32'h0, 12, 11);
        send_request(REQ_RESIZE, 0, 0, 32'h0, 4, 0);
        send_request(REQ_RESIZE, 0, 0, 32'h0, 5, 5);
        send_request(REQ_GET, 4, 4, 32'h0, 0, 0);

        // Let the pipeline empty completely before the random part
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            random_request();
            if (n == RANDOM_ITEMS / 2)
                drain();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
